// ===== sv/adler32_checksum_device_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Adler-32 checksum device assertion macros
// Concurrent check wrappers, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ADLER32_CHECKSUM_DEVICE_UNIT_DEFINES_SVH
`define ADLER32_CHECKSUM_DEVICE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check sampled on clk, disabled while rst_n is low
`define ADL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check sampled on clk, also active during reset
`define ADL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADL_ASSERT(lbl, prop, msg)
`define ADL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/adl32_pkg.sv =====
// ----------------------------------------------------------------------------
// Adler-32 checksum device package
// Request and result types, codes and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package adl32_pkg;

  // adler modulus and text length
  localparam logic [15:0] ADLER_MOD = 16'd65521;
  localparam int unsigned TEXT_LEN  = 8;

  // request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_CHAR    = 2'd0;
  localparam logic [1:0] ST_EOF     = 2'd1;
  localparam logic [1:0] ST_BADSIZE = 2'd2;

  // input request
  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic [15:0] read_position;
    logic [15:0] read_size;
  } adl_in_t;

  // output result
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] text_char;
    logic       last;
  } adl_out_t;

  // read launch from the request stage to the text emitter
  typedef struct packed {
    logic        load;
    logic [1:0]  status;
    logic [2:0]  idx;
    logic [31:0] word;
  } adl_emit_req_t;

  // nibble of the checksum word for character position idx (0 = most significant)
  function automatic logic [3:0] nib_sel(input logic [31:0] word, input logic [2:0] idx);
    logic [3:0] nib;
    case (idx)
      3'd0:    nib = word[31:28];
      3'd1:    nib = word[27:24];
      3'd2:    nib = word[23:20];
      3'd3:    nib = word[19:16];
      3'd4:    nib = word[15:12];
      3'd5:    nib = word[11:8];
      3'd6:    nib = word[7:4];
      3'd7:    nib = word[3:0];
      default: nib = 4'd0;
    endcase
    return nib;
  endfunction

  // lowercase ascii hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/adler32_checksum_device_unit.sv =====
// ----------------------------------------------------------------------------
// Adler-32 checksum device
// Byte-wide Adler-32 accumulator with a hex text read-out channel.
// ----------------------------------------------------------------------------
// Each request is registered, then handled in one pass: a write byte updates
// both sums as it leaves the request register, so writes stream at one byte
// per clock while no read waits ahead of them. A read launches into the
// result register and then occupies the result port while its text goes out
// (8 - read_position characters for a normal read, one status result for a
// short or past-end read, each held by out_stall); a request queued behind a
// read waits only while that read's text is still going out. No clearing
// pass is needed after reset.
`default_nettype none

module adler32_checksum_device_unit
  import adl32_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire adl_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output adl_out_t     out_data
);

  logic          item_vld_r, item_vld_nxt;
  adl_in_t       item_r;
  logic          item_adv;
  logic          in_take;
  logic          emit_free;
  logic          is_write;
  logic          size_bad;
  logic          pos_eof;
  logic [31:0]   word;
  adl_emit_req_t emit_req;

  assign is_write = (item_r.func == FUNC_WRITE);
  assign size_bad = ~|item_r.read_size[15:3];
  assign pos_eof  = |item_r.read_position[15:3];

  // request stage handshake
  assign item_adv = item_vld_r && (is_write || emit_free);
  assign in_stall = item_vld_r && !item_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_take) begin
      item_vld_nxt = 1'b1;
    end else if (item_adv) begin
      item_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_data;
    end
  end

  // read classification
  always_comb begin
    emit_req.load = item_adv && !is_write;
    emit_req.idx  = item_r.read_position[2:0];
    emit_req.word = word;
    if (size_bad) begin
      emit_req.status = ST_BADSIZE;
    end else if (pos_eof) begin
      emit_req.status = ST_EOF;
    end else begin
      emit_req.status = ST_CHAR;
    end
  end

  adl32_sums u_sums (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (item_adv && is_write),
    .data_byte (item_r.data_byte),
    .clr       (emit_req.load && emit_req.status == ST_CHAR),
    .word      (word)
  );

  adl32_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (emit_req),
    .free      (emit_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/adl32_sums.sv =====
// ----------------------------------------------------------------------------
// Adler-32 running sums
// Low and high sums modulo 65521, one byte added a cycle while upd is high, cleared on clr.
// ----------------------------------------------------------------------------
`default_nettype none
`include "adler32_checksum_device_unit_defines.svh"

module adl32_sums
  import adl32_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        upd,
  input  wire logic [7:0]  data_byte,
  input  wire logic        clr,
  output logic [31:0]      word
);

  logic [15:0] sum_low_r,  sum_low_nxt;
  logic [15:0] sum_high_r, sum_high_nxt;
  logic [16:0] low_ext;
  logic [16:0] high_ext;
  logic [15:0] low_new;
  logic [15:0] high_new;

  // low sum plus byte, one conditional subtract
  always_comb begin
    low_ext = {1'b0, sum_low_r} + {9'd0, data_byte};
    if (low_ext >= {1'b0, ADLER_MOD}) begin
      low_new = 16'(low_ext - {1'b0, ADLER_MOD});
    end else begin
      low_new = low_ext[15:0];
    end
  end

  // high sum plus new low sum, one conditional subtract
  always_comb begin
    high_ext = {1'b0, sum_high_r} + {1'b0, low_new};
    if (high_ext >= {1'b0, ADLER_MOD}) begin
      high_new = 16'(high_ext - {1'b0, ADLER_MOD});
    end else begin
      high_new = high_ext[15:0];
    end
  end

  // next sums
  always_comb begin
    sum_low_nxt  = sum_low_r;
    sum_high_nxt = sum_high_r;
    if (clr) begin
      sum_low_nxt  = 16'd1;
      sum_high_nxt = 16'd0;
    end else if (upd) begin
      sum_low_nxt  = low_new;
      sum_high_nxt = high_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_low_r  <= 16'd1;
      sum_high_r <= 16'd0;
    end else begin
      sum_low_r  <= sum_low_nxt;
      sum_high_r <= sum_high_nxt;
    end
  end

  assign word = {sum_high_r, sum_low_r};

  // sums stay reduced and a read leaves the reset values behind
  `ADL_ASSERT(a_low_reduced, sum_low_r < ADLER_MOD, "low sum not reduced")
  `ADL_ASSERT(a_high_reduced, sum_high_r < ADLER_MOD, "high sum not reduced")
  `ADL_ASSERT(a_clr_resets, clr |=> (sum_low_r == 16'd1 && sum_high_r == 16'd0),
              "sums not reset after read")

endmodule

`default_nettype wire

// ===== sv/adl32_emit.sv =====
// ----------------------------------------------------------------------------
// Adler-32 text emitter
// Registered result port that sends one status result or a run of hex characters per read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "adler32_checksum_device_unit_defines.svh"

module adl32_emit
  import adl32_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire adl_emit_req_t req,
  output logic               free,
  output logic               out_valid,
  input  wire logic          out_stall,
  output adl_out_t           out_data
);

  logic        out_vld_r,  out_vld_nxt;
  adl_out_t    out_data_r, out_data_nxt;
  logic [31:0] word_r,     word_nxt;
  logic [2:0]  idx_r,      idx_nxt;
  logic        take;
  logic [1:0]  sel_status;
  logic [2:0]  sel_idx;
  logic [31:0] sel_word;

  assign take = out_vld_r && !out_stall;
  assign free = !out_vld_r || (take && out_data_r.last);

  // choose between a new read and the next character of the current one
  always_comb begin
    if (req.load) begin
      sel_status = req.status;
      sel_idx    = req.idx;
      sel_word   = req.word;
    end else begin
      sel_status = ST_CHAR;
      sel_idx    = idx_r + 3'd1;
      sel_word   = word_r;
    end
  end

  // next result register
  always_comb begin
    out_vld_nxt  = out_vld_r;
    word_nxt     = word_r;
    idx_nxt      = idx_r;
    out_data_nxt = out_data_r;
    if (req.load || (take && !out_data_r.last)) begin
      out_vld_nxt            = 1'b1;
      word_nxt               = sel_word;
      idx_nxt                = sel_idx;
      out_data_nxt.status    = sel_status;
      out_data_nxt.text_char = (sel_status == ST_CHAR) ?
                               hex_char(nib_sel(sel_word, sel_idx)) : 8'd0;
      out_data_nxt.last      = (sel_status != ST_CHAR) || (sel_idx == 3'd7);
    end else if (take) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    word_r     <= word_nxt;
    idx_r      <= idx_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // result sequencing checks
  `ADL_ASSERT(a_status_last, (out_vld_r && out_data_r.status != ST_CHAR) |-> out_data_r.last,
              "status result without last")
  `ADL_ASSERT(a_char_last, (out_vld_r && out_data_r.status == ST_CHAR) |->
              (out_data_r.last == (idx_r == 3'd7)), "last misplaced in text")
  `ADL_ASSERT(a_char_step, (take && !out_data_r.last && !req.load) |=>
              (out_vld_r && idx_r == $past(idx_r) + 3'd1), "text position skipped")
  `ADL_ASSERT(a_load_free, req.load |-> free, "read launched while text busy")

endmodule

`default_nettype wire

// ===== tb/sv/adler32_checksum_device_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Adler-32 checksum device result checker
// Follows every accepted request, keeps its own copy of the two running sums,
// works out the text each read should return and compares every result taken
// from the device with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module adler32_checksum_device_unit_checker
  import adl32_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_stall,
  input  wire adl_in_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_stall,
  input  wire adl_out_t out_data,
  output int            fail_count,
  output int            pending_count
);

  // lowercase hex digits, '0' in the top byte
  localparam logic [127:0] HEX_DIGITS = "0123456789abcdef";

  // running sums as the device should hold them
  logic [15:0] sum_lo;
  logic [15:0] sum_hi;
  // results still owed by the device, oldest first
  adl_out_t    owed_text_q[$];

  // ascii digit for one nibble
  function automatic logic [7:0] hex_digit_of(input logic [3:0] nib);
    logic [127:0] shifted;
    shifted = HEX_DIGITS >> ((15 - nib) * 8);
    return shifted[7:0];
  endfunction

  // fold one accepted request into the sums and the owed results
  task automatic absorb_request(input adl_in_t req);
    logic [31:0] acc;
    logic [31:0] word;
    adl_out_t    res;
    int unsigned idx;
    res.text_char = 8'h00;
    res.last      = 1'b1;
    if (req.func == FUNC_WRITE) begin
      acc    = ({16'd0, sum_lo} + {24'd0, req.data_byte}) % {16'd0, ADLER_MOD};
      sum_lo = acc[15:0];
      acc    = ({16'd0, sum_hi} + {16'd0, sum_lo}) % {16'd0, ADLER_MOD};
      sum_hi = acc[15:0];
    end else if (req.read_size < TEXT_LEN) begin
      // undersized read wins over a bad position
      res.status = ST_BADSIZE;
      owed_text_q.push_back(res);
    end else if (req.read_position >= TEXT_LEN) begin
      res.status = ST_EOF;
      owed_text_q.push_back(res);
    end else begin
      // characters from the requested offset to the end, then clear the sums
      word = {sum_hi, sum_lo};
      for (idx = req.read_position; idx < TEXT_LEN; idx++) begin
        res.status    = ST_CHAR;
        res.text_char = hex_digit_of(word[(TEXT_LEN - 1 - idx) * 4 +: 4]);
        res.last      = (idx == TEXT_LEN - 1);
        owed_text_q.push_back(res);
      end
      sum_lo = 16'd1;
      sum_hi = 16'd0;
    end
  endtask

  // compare one taken result against the oldest owed one
  task automatic check_result(input adl_out_t got);
    adl_out_t want;
    if (owed_text_q.size() == 0) begin
      $error("unexpected result: status %0d, text_char %h, last %0d",
             got.status, got.text_char, got.last);
      fail_count++;
    end else begin
      want = owed_text_q.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        fail_count++;
      end
      if (got.text_char !== want.text_char) begin
        $error("text_char mismatch: expected %h, actual %h", want.text_char, got.text_char);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
        fail_count++;
      end
    end
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      sum_lo = 16'd1;
      sum_hi = 16'd0;
      owed_text_q.delete();
      pending_count = 0;
    end else begin
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        absorb_request(in_data);
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        check_result(out_data);
      end
      pending_count = owed_text_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/adler32_checksum_device_unit_test.sv =====
// ----------------------------------------------------------------------------
// Adler-32 checksum device testbench
// Drives writes and reads with random gaps and output stalls: a directed
// opening, mixed write runs ending in reads, an output hold-off that backs
// the device up, and a long burst that wraps the sums past the modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module adler32_checksum_device_unit_test;
  import adl32_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 20;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  adl_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  adl_out_t out_data;

  int          fail_count;
  int          pending_count;
  int unsigned requests_sent = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  bit          quiet = 1'b0;
  bit          hold_start = 1'b0;

  adler32_checksum_device_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  adler32_checksum_device_unit_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, a long hold-off on demand, none while quiet
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_left  = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 37);
      end
    end
  end

  function automatic adl_in_t make_req(input logic func, input logic [7:0] data_byte,
                                       input logic [15:0] pos, input logic [15:0] size);
    adl_in_t req;
    req.func          = func;
    req.data_byte     = data_byte;
    req.read_position = pos;
    req.read_size     = size;
    return req;
  endfunction

  // offer one request after a random gap and wait until it is taken
  task automatic send_request(input adl_in_t req);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    requests_sent++;
  endtask

  // data byte with random unused read fields
  task automatic send_write(input logic [7:0] data_byte);
    send_request(make_req(FUNC_WRITE, data_byte, 16'($urandom), 16'($urandom)));
  endtask

  // well-formed read, half the time from the first character
  task automatic send_text_read();
    logic [15:0] pos;
    logic [15:0] size;
    pos = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 7));
    case ($urandom_range(0, 3))
      0:       size = 16'd8;
      1:       size = 16'hFFFF;
      default: size = 16'($urandom_range(8, 65535));
    endcase
    send_request(make_req(FUNC_READ, 8'($urandom), pos, size));
  endtask

  // undersized read, past-end read or a plain random write
  task automatic send_odd_request();
    case ($urandom_range(0, 2))
      0: send_request(make_req(FUNC_READ, 8'($urandom), 16'($urandom),
                               16'($urandom_range(0, 7))));
      1: send_request(make_req(FUNC_READ, 8'($urandom), 16'($urandom_range(8, 65535)),
                               16'($urandom_range(8, 65535))));
      default: send_write(8'($urandom));
    endcase
  endtask

  // short write runs, each closed by a read or an odd request
  task automatic send_mixed(input int unsigned upto);
    while (requests_sent < upto) begin
      repeat ($urandom_range(0, 6)) send_write(8'($urandom));
      if ($urandom_range(0, 99) < 80) begin
        send_text_read();
      end else begin
        send_odd_request();
      end
    end
  endtask

  // sender and verdict
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset value reads back as 00000001
    send_request(make_req(FUNC_READ, 8'h00, 16'd0, 16'd8));
    // undersized reads, the size check ahead of the position check
    send_request(make_req(FUNC_READ, 8'hFF, 16'd0, 16'd0));
    send_request(make_req(FUNC_READ, 8'h00, 16'hFFFF, 16'd7));
    // past-end reads
    send_request(make_req(FUNC_READ, 8'h00, 16'd8, 16'd8));
    send_request(make_req(FUNC_READ, 8'h00, 16'hFFFF, 16'hFFFF));
    // byte extremes with the unused fields at their extremes
    send_request(make_req(FUNC_WRITE, 8'h00, 16'hFFFF, 16'hFFFF));
    send_request(make_req(FUNC_WRITE, 8'hFF, 16'd0, 16'd0));
    send_request(make_req(FUNC_WRITE, 8'h5A, 16'd0, 16'd7));
    send_request(make_req(FUNC_WRITE, 8'hA5, 16'd8, 16'd0));
    // last character only, then a full read of the cleared sums
    send_request(make_req(FUNC_READ, 8'h00, 16'd7, 16'hFFFF));
    send_request(make_req(FUNC_READ, 8'h00, 16'd0, 16'd8));
    // read from the middle of the text
    send_request(make_req(FUNC_WRITE, 8'h61, 16'd0, 16'd0));
    send_request(make_req(FUNC_READ, 8'h00, 16'd3, 16'd100));
    // rejected reads leave the sums alone
    send_request(make_req(FUNC_WRITE, 8'h01, 16'd0, 16'd0));
    send_request(make_req(FUNC_READ, 8'h00, 16'd0, 16'd7));
    send_request(make_req(FUNC_READ, 8'h00, 16'd9, 16'd8));
    send_request(make_req(FUNC_READ, 8'h00, 16'd0, 16'd8));
    send_request(make_req(FUNC_READ, 8'h00, 16'd1, 16'hFFFE));

    send_mixed(90);

    // output held off while full reads keep arriving
    hold_start = 1'b1;
    repeat (12) begin
      send_write(8'($urandom));
      send_request(make_req(FUNC_READ, 8'($urandom), 16'd0, 16'hFFFF));
    end

    // no gaps on either side; high bytes carry the low sum past the modulus
    quiet = 1'b1;
    repeat (280) begin
      send_write(($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255)) : 8'hFF);
    end
    send_text_read();
    quiet = 1'b0;

    send_mixed(430);

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
